FILE: rtl/fpb_pkg.sv
// Shared constants, payload types and control structs for the force pad balance block.
// No dependencies; every other file but fpb_chk uses this package.
`default_nettype none

package fpb_pkg;

    localparam int CHANNELS       = 8;
    localparam int RAW_W          = 12;
    localparam int D_W            = 13;   // zero-corrected count
    localparam int F_W            = 14;   // tared count
    localparam int W_W            = 16;   // total weight
    localparam int SUM_W          = 18;   // difference of eight tared counts
    localparam int RATIO_W        = 16;
    localparam int RATIO_FRAC_DEF = 13;
    localparam int DIV_STEPS      = 16;   // quotient bits, top bit flags saturation
    localparam int AXES           = 3;

    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZEROS_RIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZEROS_LEFT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR         = 2'd3;

    typedef logic        [RAW_W-1:0]   t_raw;
    typedef logic signed [D_W-1:0]     t_d;
    typedef logic signed [F_W-1:0]     t_f;
    typedef logic signed [W_W-1:0]     t_w;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [RATIO_W-1:0] t_ratio;

    typedef t_raw [CHANNELS-1:0] t_raw_vec;
    typedef t_d   [CHANNELS-1:0] t_d_vec;
    typedef t_f   [CHANNELS-1:0] t_f_vec;
    typedef t_sum [AXES-1:0]     t_sum_vec;

    typedef struct packed {
        t_w       w;
        t_sum_vec s;      // x, y, z half-sum numerators
        logic     skip;
        logic     fallen;
    } t_merged;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

endpackage

`default_nettype wire

FILE: rtl/fpb_in_if.sv
// Input channel: one beat carries the mode bit and eight raw load-cell counts.
// Depends on fpb_pkg for the count type.
`default_nettype none

interface fpb_in_if;
    logic              valid;
    logic              ready;
    logic              mode;
    fpb_pkg::t_raw     raw_0;
    fpb_pkg::t_raw     raw_1;
    fpb_pkg::t_raw     raw_2;
    fpb_pkg::t_raw     raw_3;
    fpb_pkg::t_raw     raw_4;
    fpb_pkg::t_raw     raw_5;
    fpb_pkg::t_raw     raw_6;
    fpb_pkg::t_raw     raw_7;

    modport source (output valid, mode, raw_0, raw_1, raw_2, raw_3,
                    raw_4, raw_5, raw_6, raw_7, input ready);
    modport sink   (input valid, mode, raw_0, raw_1, raw_2, raw_3,
                    raw_4, raw_5, raw_6, raw_7, output ready);
endinterface

`default_nettype wire

FILE: rtl/fpb_out_if.sv
// Output channel: one beat carries the three balance ratios, weight and flags.
// Depends on fpb_pkg for the ratio and weight types.
`default_nettype none

interface fpb_out_if;
    logic            valid;
    logic            ready;
    fpb_pkg::t_ratio x_ratio;
    fpb_pkg::t_ratio y_ratio;
    fpb_pkg::t_ratio z_ratio;
    fpb_pkg::t_w     total_weight;
    logic            fallen;
    logic            ratio_skipped;

    modport source (output valid, x_ratio, y_ratio, z_ratio, total_weight,
                    fallen, ratio_skipped, input ready);
    modport sink   (input valid, x_ratio, y_ratio, z_ratio, total_weight,
                    fallen, ratio_skipped, output ready);
endinterface

`default_nettype wire

FILE: rtl/fpb_lane.sv
// One channel lane: analog zero removal, tare store and tare subtraction.
// Depends on fpb_pkg.
`default_nettype none

module fpb_lane (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_calib,
    input  fpb_pkg::t_raw i_raw,
    input  fpb_pkg::t_raw i_zero,
    output fpb_pkg::t_d   o_d,
    output fpb_pkg::t_f   o_f
);
    import fpb_pkg::*;

    t_d r_tare;
    t_d r_d;
    t_f r_f;
    t_d n_d;
    t_f n_f;

    always_comb begin
        n_d = t_d'({1'b0, i_raw}) - t_d'({1'b0, i_zero});
        n_f = t_f'(n_d) - t_f'(r_tare);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare <= '0;
        end else if (i_en && i_calib) begin
            r_tare <= n_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
            r_f <= n_f;
        end
    end

    assign o_d = r_d;
    assign o_f = r_f;

endmodule

`default_nettype wire

FILE: rtl/fpb_merge.sv
// Merge stage: sums the lane results into the weight and the three half-sum
// numerators, and settles the fall and skip flags. Depends on fpb_pkg.
`default_nettype none

module fpb_merge (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_calib,
    input  logic              i_mirror,
    input  fpb_pkg::t_w       i_thr,
    input  fpb_pkg::t_d_vec   i_d,
    input  fpb_pkg::t_f_vec   i_f,
    output fpb_pkg::t_merged  o_res
);
    import fpb_pkg::*;

    t_merged r_res;
    t_merged n_res;
    t_sum    e [CHANNELS];

    always_comb begin
        n_res.w = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            n_res.w = n_res.w + t_w'($signed(i_d[i]));
            e[i]    = t_sum'($signed(i_f[i]));
        end
        // channel 3 reads as channel 2 after tare removal
        if (i_mirror) begin
            e[3] = e[2];
        end
        n_res.s[0] = e[4] + e[5] + e[6] + e[7] - e[0] - e[1] - e[2] - e[3];
        n_res.s[1] = e[2] + e[3] + e[6] + e[7] - e[0] - e[1] - e[4] - e[5];
        n_res.s[2] = e[0] + e[1] + e[6] + e[7] - e[2] - e[3] - e[4] - e[5];
        n_res.skip   = i_calib || (n_res.w <= 0);
        n_res.fallen = n_res.w < i_thr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: rtl/fpb_div.sv
// Restoring divider, one quotient bit per step: rounded |s| / (2w) with the sign
// of s, FRAC fraction bits, saturated to the 16-bit ratio range. Depends on fpb_pkg.
`default_nettype none

module fpb_div #(
    parameter int FRAC = fpb_pkg::RATIO_FRAC_DEF
) (
    input  logic              i_clk,
    input  fpb_pkg::t_div_ctl i_ctl,
    input  fpb_pkg::t_sum     i_s,
    input  fpb_pkg::t_w       i_w,
    output fpb_pkg::t_ratio   o_q
);
    import fpb_pkg::*;

    localparam int MAG_W = SUM_W - 1;
    localparam int NUM_W = MAG_W + FRAC + 1;
    localparam int DSH_W = W_W + DIV_STEPS - 1;
    localparam int REM_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;

    logic                 r_neg;
    logic [REM_W-1:0]     r_rem;
    logic [REM_W-1:0]     r_dsh;
    logic [DIV_STEPS-1:0] r_q;
    logic [SUM_W-1:0]     abs_s;
    logic [REM_W-1:0]     num;
    logic [REM_W-1:0]     den;
    logic                 fits;
    t_ratio               mag_q;

    always_comb begin
        abs_s = i_s[SUM_W-1] ? SUM_W'(-i_s) : SUM_W'(i_s);
        // numerator |s| * 2^FRAC + w gives round-half-away after flooring by 2w
        num   = (REM_W'(abs_s[MAG_W-1:0]) << FRAC) + REM_W'(i_w[W_W-2:0]);
        den   = REM_W'({i_w[W_W-2:0], 1'b0}) << (DIV_STEPS - 1);
        fits  = r_rem >= r_dsh;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_neg <= i_s[SUM_W-1];
            r_rem <= num;
            r_dsh <= den;
            r_q   <= '0;
        end else if (i_ctl.step) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[DIV_STEPS-2:0], fits};
            r_dsh <= r_dsh >> 1;
        end
    end

    always_comb begin
        mag_q = t_ratio'(r_q);
        if (r_q[DIV_STEPS-1]) begin
            o_q = r_neg ? {1'b1, {(RATIO_W-1){1'b0}}} : {1'b0, {(RATIO_W-1){1'b1}}};
        end else begin
            o_q = r_neg ? -mag_q : mag_q;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/force_pad_balance_top.sv
// Force pad balance top level: config registers, eight channel lanes, merge
// stage, three divider lanes and the result register. Depends on fpb_pkg,
// fpb_in_if, fpb_out_if, fpb_lane, fpb_merge and fpb_div.
//
//  channel  | direction | beat contents
//  ---------+-----------+----------------------------------------------------
//  i_item   | in        | mode, raw_0 .. raw_7
//  o_res    | out       | x/y/z_ratio, total_weight, fallen, ratio_skipped
//  i_cfg_*  | in        | write enable, register index, 48-bit write data
//
// The lanes register at the accept edge; the result beat then passes the merge
// register, the divider load, 16 divider steps (one quotient bit each) and the
// hand-off into the result register, which waits while an older result stalls.
// The three ratio dividers run side by side. Input is taken only when idle, so no
// new item is taken before the last one has gone to the result register. A waiting
// result does not block the next item until that item needs the result register.
// Reset clears the tares and loads the register defaults at once; no clearing pass.
`default_nettype none

module force_pad_balance_top #(
    parameter int RATIO_FRACTION_BITS = fpb_pkg::RATIO_FRAC_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fpb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fpb_pkg::CFG_W-1:0]       i_cfg_data,
    fpb_in_if.sink                          i_item,
    fpb_out_if.source                       o_res
);
    import fpb_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MERGE = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [CFG_W-1:0] r_zeros_right;
    logic [CFG_W-1:0] r_zeros_left;
    t_w               r_thr;
    logic             r_mirror;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_calib;

    logic             r_out_valid;
    t_ratio           r_x, r_y, r_z;
    t_w               r_w;
    logic             r_fallen;
    logic             r_skip;

    logic             accept;
    logic             emit;
    t_raw_vec         raw;
    t_raw_vec         lane_raw;
    t_raw_vec         lane_zero;
    t_d_vec           d;
    t_f_vec           f;
    t_merged          merged;
    t_div_ctl         div_ctl;
    t_ratio           q [AXES];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zeros_right <= '0;
            r_zeros_left  <= '0;
            r_thr         <= '0;
            r_mirror      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ZEROS_RIGHT:    r_zeros_right <= i_cfg_data;
                CFG_ZEROS_LEFT:     r_zeros_left  <= i_cfg_data;
                CFG_FALL_THRESHOLD: r_thr         <= t_w'(i_cfg_data[W_W-1:0]);
                CFG_MIRROR:         r_mirror      <= i_cfg_data[0];
                default:            r_mirror      <= r_mirror;
            endcase
        end
    end

    assign raw[0] = i_item.raw_0;
    assign raw[1] = i_item.raw_1;
    assign raw[2] = i_item.raw_2;
    assign raw[3] = i_item.raw_3;
    assign raw[4] = i_item.raw_4;
    assign raw[5] = i_item.raw_5;
    assign raw[6] = i_item.raw_6;
    assign raw[7] = i_item.raw_7;

    assign i_item.ready = (r_state == ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign emit         = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);

    // channel lanes; lane 3 takes channel 2 input when mirrored
    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        if (i < CHANNELS / 2) begin : g_right
            assign lane_zero[i] = (i == 3 && r_mirror) ? r_zeros_right[2*RAW_W +: RAW_W]
                                                       : r_zeros_right[i*RAW_W +: RAW_W];
        end else begin : g_left
            assign lane_zero[i] = r_zeros_left[(i - CHANNELS/2)*RAW_W +: RAW_W];
        end
        assign lane_raw[i] = (i == 3 && r_mirror) ? raw[2] : raw[i];

        fpb_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (accept),
            .i_calib (i_item.mode),
            .i_raw   (lane_raw[i]),
            .i_zero  (lane_zero[i]),
            .o_d     (d[i]),
            .o_f     (f[i])
        );
    end

    fpb_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (r_state == ST_MERGE),
        .i_calib  (r_calib),
        .i_mirror (r_mirror),
        .i_thr    (r_thr),
        .i_d      (d),
        .i_f      (f),
        .o_res    (merged)
    );

    assign div_ctl.load = (r_state == ST_LOAD);
    assign div_ctl.step = (r_state == ST_DIV);

    for (genvar a = 0; a < AXES; a++) begin : g_div
        fpb_div #(
            .FRAC (RATIO_FRACTION_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_ctl (div_ctl),
            .i_s   (merged.s[a]),
            .i_w   (merged.w),
            .o_q   (q[a])
        );
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = ST_MERGE;
            ST_MERGE: n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = ST_DONE;
            ST_DONE:  if (emit) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_calib <= i_item.mode;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_x      <= merged.skip ? '0 : q[0];
            r_y      <= merged.skip ? '0 : q[1];
            r_z      <= merged.skip ? '0 : q[2];
            r_w      <= merged.w;
            r_fallen <= merged.fallen;
            r_skip   <= merged.skip;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.x_ratio       = r_x;
    assign o_res.y_ratio       = r_y;
    assign o_res.z_ratio       = r_z;
    assign o_res.total_weight  = r_w;
    assign o_res.fallen        = r_fallen;
    assign o_res.ratio_skipped = r_skip;

endmodule

`default_nettype wire

FILE: rtl/fpb_chk.sv
// Port-level checks for force_pad_balance_top, attached by the bind below.
// Uses no package types; the bind below ties it to the top level's ports.
`default_nettype none

module fpb_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [15:0]   x_ratio,
    input logic signed [15:0]   y_ratio,
    input logic signed [15:0]   z_ratio,
    input logic signed [15:0]   total_weight,
    input logic                 skipped
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_ratio) && $stable(total_weight))
        else $error("result beat changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && skipped |-> x_ratio == 0 && y_ratio == 0 && z_ratio == 0)
        else $error("skipped result carries nonzero ratio");

    a_weight_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && total_weight <= 0 |-> skipped)
        else $error("ratio given for non-positive weight");

endmodule

bind force_pad_balance_top fpb_chk u_fpb_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_valid     (i_item.valid),
    .in_ready     (i_item.ready),
    .out_valid    (o_res.valid),
    .out_ready    (o_res.ready),
    .x_ratio      (o_res.x_ratio),
    .y_ratio      (o_res.y_ratio),
    .z_ratio      (o_res.z_ratio),
    .total_weight (o_res.total_weight),
    .skipped      (o_res.ratio_skipped)
);

`default_nettype wire

FILE: sim/tb_force_pad_balance_top.sv
// Self-checking testbench for force_pad_balance_top: directed and random load-cell beats,
// random stalls on both channels, in-bench prediction of ratios, weight and flags.
// Depends on fpb_pkg, fpb_in_if, fpb_out_if and the force_pad_balance_top RTL.
module tb_force_pad_balance_top;
    import fpb_pkg::*;

    localparam int FRAC_BITS     = RATIO_FRAC_DEF;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 400;
    localparam int SEG_ITEMS     = 50;
    localparam logic MODE_MEASURE   = 1'b0;
    localparam logic MODE_CALIBRATE = 1'b1;

    typedef struct packed {
        logic     mode;
        t_raw_vec raw;
    } t_sample;

    typedef struct packed {
        t_ratio x;
        t_ratio y;
        t_ratio z;
        t_w     w;
        logic   fallen;
        logic   skipped;
    } t_balance;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = CFG_ZEROS_RIGHT;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic    drv_valid = 1'b0;
    t_sample drv_beat  = '0;
    logic    res_ready = 1'b0;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    logic long_hold_armed = 1'b0;
    logic long_hold_done  = 1'b0;
    int hold_left       = 0;
    int errors          = 0;

    // Predictor copy of the configuration and the tare store
    logic [CFG_W-1:0] zeros_r   = '0;
    logic [CFG_W-1:0] zeros_l   = '0;
    int               thr_lim   = 0;
    logic             mirror_on = 1'b1;
    t_d               tare_store [CHANNELS] = '{default: '0};

    t_sample  sample_queue [$];
    t_balance balance_due  [$];

    fpb_in_if  item_if ();
    fpb_out_if res_if ();

    assign item_if.valid = drv_valid;
    assign item_if.mode  = drv_beat.mode;
    assign item_if.raw_0 = drv_beat.raw[0];
    assign item_if.raw_1 = drv_beat.raw[1];
    assign item_if.raw_2 = drv_beat.raw[2];
    assign item_if.raw_3 = drv_beat.raw[3];
    assign item_if.raw_4 = drv_beat.raw[4];
    assign item_if.raw_5 = drv_beat.raw[5];
    assign item_if.raw_6 = drv_beat.raw[6];
    assign item_if.raw_7 = drv_beat.raw[7];
    assign res_if.ready  = res_ready;

    force_pad_balance_top #(
        .RATIO_FRACTION_BITS(FRAC_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_if),
        .o_res      (res_if)
    );

    always #6 i_clk = ~i_clk;

    function automatic int zero_count(int ch);
        logic [CFG_W-1:0] r;
        r = (ch < 4) ? zeros_r : zeros_l;
        return int'(r[12*(ch%4) +: 12]);
    endfunction

    // s / (2w) rounded half away from zero, saturated to the ratio width
    function automatic t_ratio balance_ratio(int s, int w);
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        mag = (s < 0) ? longint'(-s) : longint'(s);
        den = longint'(w);
        mag = mag << (FRAC_BITS - 1);
        q = (2 * mag + den) / (2 * den);
        if (s < 0) begin
            if (q > 32768) q = 32768;
            return t_ratio'(-longint'(q));
        end
        if (q > 32767) q = 32767;
        return t_ratio'(q);
    endfunction

    // Work out the result of one beat; calibrate beats reload the tares
    function automatic t_balance predict_balance(t_sample s);
        int d [CHANNELS];
        int f [CHANNELS];
        int w;
        int sx;
        int sy;
        int sz;
        t_balance r;
        w = 0;
        for (int i = 0; i < CHANNELS; i++) begin
            d[i] = int'(s.raw[i]) - zero_count(i);
            if (i == 3 && mirror_on) d[3] = d[2];
            w += d[i];
        end
        r = '0;
        r.skipped = 1'b1;
        if (s.mode == MODE_CALIBRATE) begin
            for (int i = 0; i < CHANNELS; i++) tare_store[i] = t_d'(d[i]);
        end else begin
            for (int i = 0; i < CHANNELS; i++) f[i] = d[i] - int'(tare_store[i]);
            if (mirror_on) f[3] = f[2];
            if (w > 0) begin
                sx = f[4] + f[5] + f[6] + f[7] - f[0] - f[1] - f[2] - f[3];
                sy = f[2] + f[3] + f[6] + f[7] - f[0] - f[1] - f[4] - f[5];
                sz = f[0] + f[1] + f[6] + f[7] - f[2] - f[3] - f[4] - f[5];
                r.x = balance_ratio(sx, w);
                r.y = balance_ratio(sy, w);
                r.z = balance_ratio(sz, w);
                r.skipped = 1'b0;
            end
        end
        r.w      = t_w'(w);
        r.fallen = (w < thr_lim);
        return r;
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        int kind;
        int v;
        s.mode = ($urandom_range(9) == 0) ? MODE_CALIBRATE : MODE_MEASURE;
        kind = $urandom_range(9);
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (kind <= 5) begin
                v = $urandom_range(4095);
            end else if (kind <= 7) begin
                // hover around the analog zero: small weight, large ratios
                v = zero_count(ch) + int'($urandom_range(16)) - 6;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
            end else begin
                v = $urandom_range(1) ? 4095 : 0;
            end
            s.raw[ch] = t_raw'(v);
        end
        return s;
    endfunction

    function automatic logic [CFG_W-1:0] random_zeros();
        logic [CFG_W-1:0] z;
        z = '0;
        case ($urandom_range(7))
            0: z = '0;
            1: z = '1;
            2: begin
                z[47:32] = 16'($urandom_range(16'hFFFF));
                z[31:0]  = $urandom;
            end
            default: begin
                for (int k = 0; k < 4; k++) z[12*k +: 12] = 12'($urandom_range(1023));
            end
        endcase
        return z;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_ZEROS_RIGHT:    zeros_r   = data;
            CFG_ZEROS_LEFT:     zeros_l   = data;
            CFG_FALL_THRESHOLD: thr_lim   = int'($signed(data[15:0]));
            CFG_MIRROR:         mirror_on = data[0];
            default: ;
        endcase
    endtask

    task automatic random_config();
        logic [CFG_W-1:0] data;
        int t;
        write_reg(CFG_ZEROS_RIGHT, random_zeros());
        write_reg(CFG_ZEROS_LEFT, random_zeros());
        case ($urandom_range(5))
            0: t = -32760;
            1: t = 32760;
            2: t = 0;
            default: t = int'($urandom_range(40000)) - 8000;
        endcase
        data[47:16] = $urandom;
        data[15:0]  = t[15:0];
        write_reg(CFG_FALL_THRESHOLD, data);
        data[47:32] = 16'($urandom_range(16'hFFFF));
        data[31:0]  = $urandom;
        write_reg(CFG_MIRROR, data);
    endtask

    task automatic push_sample(logic mode, t_raw_vec raw);
        t_sample s;
        s.mode = mode;
        s.raw  = raw;
        sample_queue.push_back(s);
    endtask

    // Wait until every beat is sent and every result is back, then a margin
    task automatic settle();
        while (sample_queue.size() != 0 || drv_valid || balance_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : driver
        logic    nxt_valid;
        t_sample nxt;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            nxt_valid = drv_valid;
            nxt       = drv_beat;
            if (drv_valid && item_if.ready) begin
                balance_due.push_back(predict_balance(drv_beat));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && sample_queue.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt       = sample_queue.pop_front();
                nxt_valid = 1'b1;
            end
            drv_valid <= nxt_valid;
            drv_beat  <= nxt;
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_armed && !long_hold_done) begin
            // hold off long enough that the block backs up into its input
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            res_ready      <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_balance want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (balance_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, weight %0d",
                         $time, res_if.total_weight);
                errors++;
            end else begin
                want = balance_due.pop_front();
                compare_field("x_ratio", want.x, res_if.x_ratio);
                compare_field("y_ratio", want.y, res_if.y_ratio);
                compare_field("z_ratio", want.z, res_if.z_ratio);
                compare_field("total_weight", want.w, res_if.total_weight);
                compare_field("fallen", want.fallen, res_if.fallen);
                compare_field("ratio_skipped", want.skipped, res_if.ratio_skipped);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((drv_valid && item_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("force_pad_balance_top: mismatch");
        $finish;
    end

    initial begin : stimulus
        t_raw_vec rv;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 21;
        recv_idle_pct = 76;

        // Reset defaults: zeros cleared, threshold zero, mirror on
        push_sample(MODE_MEASURE, {CHANNELS{12'd0}});
        push_sample(MODE_MEASURE, {CHANNELS{12'd4095}});
        push_sample(MODE_CALIBRATE, {CHANNELS{12'd0}});
        rv = {CHANNELS{12'd0}};
        rv[4] = 12'd1;
        push_sample(MODE_MEASURE, rv);
        // Heavy right tares with a weight of one: positive saturation
        push_sample(MODE_CALIBRATE, {{4{12'd0}}, {4{12'd4095}}});
        push_sample(MODE_MEASURE, rv);
        // Heavy left tares: negative saturation
        push_sample(MODE_CALIBRATE, {{4{12'd4095}}, {4{12'd0}}});
        rv = {CHANNELS{12'd0}};
        rv[0] = 12'd1;
        push_sample(MODE_MEASURE, rv);
        // Odd half-sums over a weight of 8192: ratios land exactly on a half
        push_sample(MODE_CALIBRATE, rv);
        push_sample(MODE_MEASURE, {CHANNELS{12'd1024}});
        push_sample(MODE_CALIBRATE, {CHANNELS{12'd4095}});
        push_sample(MODE_MEASURE, {CHANNELS{12'd4095}});
        push_sample(MODE_MEASURE, {4{12'hAAA, 12'h555}});
        settle();

        write_reg(CFG_ZEROS_RIGHT, '1);
        write_reg(CFG_ZEROS_LEFT, '0);
        write_reg(CFG_FALL_THRESHOLD, {32'hFFFF_0000, 16'h7FF8});
        write_reg(CFG_MIRROR, 48'h2);
        push_sample(MODE_MEASURE, {CHANNELS{12'd0}});
        push_sample(MODE_CALIBRATE, {CHANNELS{12'd0}});
        push_sample(MODE_MEASURE, {CHANNELS{12'd4095}});
        push_sample(MODE_MEASURE, {4{12'h555, 12'hAAA}});
        settle();

        write_reg(CFG_ZEROS_LEFT, '1);
        write_reg(CFG_FALL_THRESHOLD, {32'h0F0F_F0F0, 16'h8008});
        write_reg(CFG_MIRROR, '1);
        // Most negative weight sits exactly on the lowest threshold
        push_sample(MODE_MEASURE, {CHANNELS{12'd0}});
        push_sample(MODE_MEASURE, {CHANNELS{12'd4095}});
        push_sample(MODE_CALIBRATE, {CHANNELS{12'd4095}});

        for (int phase = 0; phase < 3; phase++) begin
            for (int seg = 0; seg < 5; seg++) begin
                settle();
                if (seg == 0) begin
                    send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 76 : 0;
                    recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 21 : 0;
                    if (phase == 2) long_hold_armed = 1'b1;
                end
                random_config();
                repeat (SEG_ITEMS) sample_queue.push_back(random_sample());
            end
        end
        settle();

        if (errors == 0 && balance_due.size() == 0) begin
            $display("force_pad_balance_top: match");
        end else begin
            $display("force_pad_balance_top: mismatch");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/fpb_pkg.sv
rtl/fpb_in_if.sv
rtl/fpb_out_if.sv
rtl/fpb_lane.sv
rtl/fpb_merge.sv
rtl/fpb_div.sv
rtl/force_pad_balance_top.sv
rtl/fpb_chk.sv
sim/tb_force_pad_balance_top.sv
